[design/ctd_pkg.sv]
// Shared types and constants for the counting trie dictionary.
// No dependencies; every design file imports this package.
package ctd_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int USED_W     = NODE_W + 1;
  localparam int ALPHA      = 26;
  localparam int SYM_W      = 5;
  localparam int MAX_WORD   = 32;
  localparam int IDX_W      = $clog2(MAX_WORD);
  localparam int LEN_W      = IDX_W + 1;
  localparam int CNT_W      = 16;
  localparam int ACT_W      = 2;
  localparam int STAT_W     = 2;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PREFIX = 2'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_POOL_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_TOO_LONG  = 2'd3;

  // One node: its counts and its child links (zero means no child).
  typedef struct packed {
    logic [CNT_W-1:0]             word;
    logic [CNT_W-1:0]             prefix;
    logic [ALPHA-1:0][NODE_W-1:0] link;
  } ctd_row_t;

  // Letter buffer view seen by the engine.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [SYM_W-1:0] sym;
  } ctd_buf_t;

  // Finished request result.
  typedef struct packed {
    logic              valid;
    logic [CNT_W-1:0]  count;
    logic [STAT_W-1:0] status;
  } ctd_res_t;

endpackage

[design/counting_trie_dictionary.sv]
// Top level of the counting trie dictionary: stream ports and result register.
// Depends on ctd_pkg, ctd_node_ram, ctd_word_buf and ctd_engine.
//
// A word arrives one letter per request; the request marked by in_tlast names the
// operation (insert, search, prefix count, remove) and runs it over the whole
// buffered word. Letters are taken one per cycle while the engine is idle. Each
// trie level costs one read of its node row, and insert and remove walk the path
// twice (check, then update). Words longer than 32 letters are refused with
// status 3 and no change; an insert that needs more free nodes than remain is
// refused with status 2. After reset the block clears its 4096-row node store,
// one row a cycle, and holds in_tready low until the clearing is done. The
// result sits in an output register; a new word can be collected while it waits.
module counting_trie_dictionary (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [4:0] letter, [7:5] zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] count
  output logic [1:0]  out_tuser   // [1:0] status
);
  import ctd_pkg::*;

  logic              in_acc;
  logic              idle;
  logic              res_taken;
  logic [LEN_W-1:0]  buf_idx;
  logic              buf_clear;
  ctd_buf_t          word;
  ctd_res_t          res;
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  ctd_row_t          wr_row;
  logic              rd_en;
  logic [NODE_W-1:0] rd_addr;
  ctd_row_t          rd_row;

  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  out_count_r;
  logic [STAT_W-1:0] out_stat_r;

  // Take letters only while the engine is waiting for a word.
  assign in_tready = idle;
  assign in_acc    = in_tvalid && in_tready;

  // Move the finished result into the output register when it is free.
  assign res_taken = res.valid && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_taken) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_count_r <= res.count;
      out_stat_r  <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_count_r;
  assign out_tuser  = out_stat_r;

  ctd_word_buf u_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (in_acc),
    .wr_sym (in_tdata[SYM_W-1:0]),
    .clear  (buf_clear),
    .rd_idx (buf_idx),
    .view   (word)
  );

  ctd_node_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (wr_row),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_row  (rd_row)
  );

  ctd_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc && in_tlast),
    .start_act (in_tuser),
    .res_taken (res_taken),
    .word      (word),
    .rd_row    (rd_row),
    .idle      (idle),
    .buf_idx   (buf_idx),
    .buf_clear (buf_clear),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_row    (wr_row),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .res       (res)
  );

endmodule

[design/ctd_node_ram.sv]
// Node store: one row per trie node, one write and one read port.
// Depends on ctd_pkg.
module ctd_node_ram (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ctd_pkg::NODE_W-1:0] wr_addr,
  input  ctd_pkg::ctd_row_t         wr_row,
  input  logic                      rd_en,
  input  logic [ctd_pkg::NODE_W-1:0] rd_addr,
  output ctd_pkg::ctd_row_t         rd_row
);
  import ctd_pkg::*;

  ctd_row_t mem [NODE_COUNT];
  ctd_row_t rd_row_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_row_r <= mem[rd_addr];
    end
  end

  assign rd_row = rd_row_r;

endmodule

[design/ctd_word_buf.sv]
// Letter buffer for the word being collected, with saturating length.
// Depends on ctd_pkg.
module ctd_word_buf (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [ctd_pkg::SYM_W-1:0] wr_sym,
  input  logic                      clear,
  input  logic [ctd_pkg::LEN_W-1:0] rd_idx,
  output ctd_pkg::ctd_buf_t         view
);
  import ctd_pkg::*;

  logic [SYM_W-1:0] letters_r [MAX_WORD];
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] len_nxt;
  logic [SYM_W-1:0] sym_clamped;

  // Fold letters beyond the alphabet onto the last one.
  assign sym_clamped = (wr_sym >= SYM_W'(ALPHA)) ? SYM_W'(ALPHA - 1) : wr_sym;

  always_comb begin
    len_nxt = len_r;
    if (clear) begin
      len_nxt = '0;
    end else if (wr_en) begin
      if (len_r < LEN_W'(MAX_WORD)) begin
        len_nxt = len_r + 1'b1;
      end else begin
        len_nxt = LEN_W'(MAX_WORD + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !clear && len_r < LEN_W'(MAX_WORD)) begin
      letters_r[len_r[IDX_W-1:0]] <= sym_clamped;
    end
  end

  assign view.len = len_r;
  assign view.sym = letters_r[rd_idx[IDX_W-1:0]];

endmodule

[design/ctd_engine.sv]
// Request sequencer: clearing pass, check walk and update walk over the node store.
// Depends on ctd_pkg; drives ctd_node_ram and ctd_word_buf.
module ctd_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ctd_pkg::ACT_W-1:0]  start_act,
  input  logic                       res_taken,
  input  ctd_pkg::ctd_buf_t          word,
  input  ctd_pkg::ctd_row_t          rd_row,
  output logic                       idle,
  output logic [ctd_pkg::LEN_W-1:0]  buf_idx,
  output logic                       buf_clear,
  output logic                       wr_en,
  output logic [ctd_pkg::NODE_W-1:0] wr_addr,
  output ctd_pkg::ctd_row_t          wr_row,
  output logic                       rd_en,
  output logic [ctd_pkg::NODE_W-1:0] rd_addr,
  output ctd_pkg::ctd_res_t          res
);
  import ctd_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic [2:0]        state_r, state_nxt;
  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [NODE_W-1:0] node_r, node_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic [NODE_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;

  logic [NODE_W-1:0] child;
  logic              present;
  logic [USED_W-1:0] free_nodes;
  logic [USED_W-1:0] need_nodes;
  ctd_row_t          row_mod;

  assign child      = rd_row.link[word.sym];
  assign present    = (node_r == '0) || (rd_row.prefix != '0);
  assign free_nodes = USED_W'(NODE_COUNT) - used_r;
  assign need_nodes = USED_W'(word.len - idx_r);

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    node_nxt  = node_r;
    idx_nxt   = idx_r;
    used_nxt  = used_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    stat_nxt  = stat_r;
    wr_en     = 1'b0;
    wr_addr   = node_r;
    row_mod   = rd_row;
    rd_en     = 1'b0;
    rd_addr   = '0;
    buf_clear = 1'b0;

    case (state_r)
      S_CLEAR: begin
        // Zero one row per cycle after reset.
        wr_en   = 1'b1;
        wr_addr = clr_r;
        row_mod = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == NODE_W'(NODE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          act_nxt   = start_act;
          state_nxt = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        node_nxt = '0;
        idx_nxt  = '0;
        if (word.len > LEN_W'(MAX_WORD)) begin
          cnt_nxt   = '0;
          stat_nxt  = ST_TOO_LONG;
          state_nxt = S_RESULT;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (act_r == ACT_INSERT) begin
          // Count the existing part of the path.
          if (idx_r == word.len || child == '0) begin
            if (need_nodes > free_nodes) begin
              cnt_nxt   = '0;
              stat_nxt  = ST_POOL_FULL;
              state_nxt = S_RESULT;
            end else begin
              rd_en     = 1'b1;
              node_nxt  = '0;
              idx_nxt   = '0;
              state_nxt = S_UPDATE;
            end
          end else begin
            rd_en    = 1'b1;
            rd_addr  = child;
            node_nxt = child;
            idx_nxt  = idx_r + 1'b1;
          end
        end else if (!present) begin
          cnt_nxt   = '0;
          stat_nxt  = ST_NOT_FOUND;
          state_nxt = S_RESULT;
        end else if (idx_r == word.len) begin
          if (act_r == ACT_PREFIX) begin
            cnt_nxt   = rd_row.prefix;
            stat_nxt  = ST_OK;
            state_nxt = S_RESULT;
          end else if (rd_row.word == '0) begin
            cnt_nxt   = '0;
            stat_nxt  = ST_NOT_FOUND;
            state_nxt = S_RESULT;
          end else if (act_r == ACT_SEARCH) begin
            cnt_nxt   = rd_row.word;
            stat_nxt  = ST_OK;
            state_nxt = S_RESULT;
          end else begin
            rd_en     = 1'b1;
            node_nxt  = '0;
            idx_nxt   = '0;
            state_nxt = S_UPDATE;
          end
        end else if (child == '0) begin
          cnt_nxt   = '0;
          stat_nxt  = ST_NOT_FOUND;
          state_nxt = S_RESULT;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = child;
          node_nxt = child;
          idx_nxt  = idx_r + 1'b1;
        end
      end
      S_UPDATE: begin
        // Adjust this node's counts and links, write it back, fetch the child.
        wr_en = 1'b1;
        if (node_r != '0) begin
          if (act_r == ACT_INSERT) begin
            if (rd_row.prefix != CNT_MAX) begin
              row_mod.prefix = rd_row.prefix + 1'b1;
            end
          end else if (rd_row.prefix != '0) begin
            row_mod.prefix = rd_row.prefix - 1'b1;
          end
        end
        if (idx_r == word.len) begin
          if (act_r == ACT_INSERT) begin
            if (rd_row.word != CNT_MAX) begin
              row_mod.word = rd_row.word + 1'b1;
            end
          end else if (rd_row.word != '0) begin
            row_mod.word = rd_row.word - 1'b1;
          end
          cnt_nxt   = row_mod.word;
          stat_nxt  = ST_OK;
          state_nxt = S_RESULT;
        end else begin
          rd_en = 1'b1;
          if (act_r == ACT_INSERT && child == '0) begin
            row_mod.link[word.sym] = used_r[NODE_W-1:0];
            rd_addr  = used_r[NODE_W-1:0];
            node_nxt = used_r[NODE_W-1:0];
            used_nxt = used_r + 1'b1;
          end else begin
            rd_addr  = child;
            node_nxt = child;
          end
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_RESULT: begin
        if (res_taken) begin
          buf_clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      used_r  <= USED_W'(1);
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    node_r <= node_nxt;
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    stat_r <= stat_nxt;
  end

  assign wr_row     = row_mod;
  assign idle       = (state_r == S_IDLE);
  assign buf_idx    = idx_r;
  assign res.valid  = (state_r == S_RESULT);
  assign res.count  = cnt_r;
  assign res.status = stat_r;

endmodule

[verif/counting_trie_dictionary_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the counting trie dictionary: letters stream in, one result
// per word comes back and is compared with an in-bench trie predictor.
// Depends on ctd_pkg and the counting_trie_dictionary top level.
module counting_trie_dictionary_tb;
  import ctd_pkg::*;

  typedef struct {
    logic [ACT_W-1:0] action;
    logic [4:0]       letter;
    logic             last;
  } letter_req_t;

  typedef struct {
    logic [CNT_W-1:0]  count;
    logic [STAT_W-1:0] status;
  } lookup_t;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0] out_tuser;

  counting_trie_dictionary dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a private trie over the same node pool.
  logic [NODE_W-1:0] kid [NODE_COUNT*ALPHA];
  logic [CNT_W-1:0]  pfx_cnt [NODE_COUNT];
  logic [CNT_W-1:0]  wrd_cnt [NODE_COUNT];
  int                pool_used;
  int                spell [MAX_WORD];
  int                spell_len;

  letter_req_t pending_reqs[$];
  lookup_t     expected_lookups[$];
  int          mismatches = 0;
  int          cycles = 0;

  task automatic report(input string what);
    mismatches++;
    $display("mismatch: %s", what);
  endtask

  // Follow present nodes; return 0 when the path breaks.
  function automatic int trace_word();
    int node, nx;
    node = 0;
    for (int i = 0; i < spell_len; i++) begin
      nx = kid[node*ALPHA + spell[i]];
      if (nx == 0 || pfx_cnt[nx] == 0) return 0;
      node = nx;
    end
    return node;
  endfunction

  function automatic void predict_letter(letter_req_t r);
    int sym, node, depth, nx, fin;
    lookup_t res;
    sym = (r.letter >= ALPHA) ? ALPHA - 1 : r.letter;
    if (spell_len < MAX_WORD) begin
      spell[spell_len] = sym;
      spell_len++;
    end else begin
      spell_len = MAX_WORD + 1;
    end
    if (!r.last) return;
    res.count = '0;
    res.status = ST_NOT_FOUND;
    if (spell_len > MAX_WORD) begin
      res.status = ST_TOO_LONG;
    end else if (r.action == ACT_INSERT) begin
      node = 0;
      depth = 0;
      while (depth < spell_len && kid[node*ALPHA + spell[depth]] != 0) begin
        node = kid[node*ALPHA + spell[depth]];
        depth++;
      end
      if (spell_len - depth > NODE_COUNT - pool_used) begin
        res.status = ST_POOL_FULL;
      end else begin
        node = 0;
        for (int i = 0; i < spell_len; i++) begin
          nx = kid[node*ALPHA + spell[i]];
          if (nx == 0) begin
            nx = pool_used;
            pool_used++;
            kid[node*ALPHA + spell[i]] = NODE_W'(nx);
          end
          if (pfx_cnt[nx] != CNT_MAX) pfx_cnt[nx]++;
          node = nx;
        end
        if (wrd_cnt[node] != CNT_MAX) wrd_cnt[node]++;
        res.count = wrd_cnt[node];
        res.status = ST_OK;
      end
    end else begin
      fin = trace_word();
      if (fin != 0) begin
        if (r.action == ACT_PREFIX) begin
          res.count = pfx_cnt[fin];
          res.status = ST_OK;
        end else if (wrd_cnt[fin] != 0) begin
          if (r.action == ACT_REMOVE) begin
            node = 0;
            for (int i = 0; i < spell_len; i++) begin
              node = kid[node*ALPHA + spell[i]];
              if (pfx_cnt[node] != 0) pfx_cnt[node]--;
            end
            wrd_cnt[fin]--;
          end
          res.count = wrd_cnt[fin];
          res.status = ST_OK;
        end
      end
    end
    spell_len = 0;
    expected_lookups.push_back(res);
  endfunction

  // Queue one word; the action rides on every letter but only the last one counts.
  task automatic queue_word(input int letters[$], input logic [ACT_W-1:0] act);
    letter_req_t r;
    foreach (letters[i]) begin
      r.action = (i == letters.size() - 1) ? act : ACT_W'($urandom);
      r.letter = 5'(letters[i]);
      r.last = (i == letters.size() - 1);
      pending_reqs.push_back(r);
    end
  endtask

  // Wait until every queued request is sent and every result is back.
  task automatic drain();
    while (pending_reqs.size() != 0 || expected_lookups.size() != 0) @(posedge clk);
  endtask

  // Driver: hold each request until accepted, then draw a fresh gap.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_letter(pending_reqs.pop_front());
        send_gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) send_gap = 0;
      end
      if (in_tvalid && !in_tready) begin
        // keep presenting the same request
      end else if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {3'b000, pending_reqs[0].letter};
        in_tuser <= pending_reqs[0].action;
        in_tlast <= pending_reqs[0].last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result, then draw a stall for the next.
  int recv_gap = 0;
  always @(posedge clk) begin
    lookup_t want;
    cycles++;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_lookups.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = expected_lookups.pop_front();
          if (out_tdata !== want.count)
            report($sformatf("count %0d, want %0d", out_tdata, want.count));
          if (out_tuser !== want.status)
            report($sformatf("status %0d, want %0d", out_tuser, want.status));
        end
        recv_gap = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) recv_gap = 0;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic void random_word(ref int w[$], input int maxlen, input int alpha);
    int n;
    w = {};
    n = $urandom_range(1, maxlen);
    for (int i = 0; i < n; i++) w.push_back($urandom_range(0, alpha - 1));
  endfunction

  initial begin
    int w[$];
    int dict[$][$];
    int pick;
    int r;
    logic [ACT_W-1:0] act;

    for (int i = 0; i < NODE_COUNT*ALPHA; i++) kid[i] = '0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      pfx_cnt[i] = '0;
      wrd_cnt[i] = '0;
    end
    pool_used = 1;
    spell_len = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every action, letter extremes, out-of-alphabet letters, misses,
    // remove to zero, and words of 32 and 33 letters.
    queue_word('{0}, ACT_SEARCH);
    queue_word('{0}, ACT_INSERT);
    queue_word('{0}, ACT_INSERT);
    queue_word('{0}, ACT_SEARCH);
    queue_word('{25, 31}, ACT_INSERT);
    queue_word('{25, 25}, ACT_SEARCH);
    queue_word('{25, 26}, ACT_PREFIX);
    queue_word('{25}, ACT_PREFIX);
    queue_word('{25}, ACT_SEARCH);
    queue_word('{25}, ACT_REMOVE);
    queue_word('{25, 25}, ACT_REMOVE);
    queue_word('{25, 25}, ACT_REMOVE);
    queue_word('{25}, ACT_PREFIX);
    queue_word('{3, 4}, ACT_PREFIX);
    w = {};
    for (int i = 0; i < MAX_WORD; i++) w.push_back(i % 32);
    queue_word(w, ACT_INSERT);
    queue_word(w, ACT_SEARCH);
    w.push_back(7);
    queue_word(w, ACT_INSERT);
    queue_word('{1}, ACT_SEARCH);

    // Let the directed part drain before the random phase.
    drain();

    // Random: mostly operations on a small dictionary so hits are common.
    for (int n = 0; n < 240; n++) begin
      r = $urandom_range(0, 99);
      if (dict.size() > 0 && r < 65) begin
        pick = $urandom_range(0, dict.size() - 1);
        w = dict[pick];
        if ($urandom_range(0, 3) == 0 && w.size() > 1) w = w[0:$urandom_range(0, w.size()-2)];
      end else if (r < 97) begin
        random_word(w, 5, 32);
        if (dict.size() < 24) dict.push_back(w);
      end else begin
        random_word(w, 40, 32);
      end
      act = ACT_W'($urandom);
      if ($urandom_range(0, 2) == 0) act = ACT_INSERT;
      queue_word(w, act);
      if (n == 120) begin
        drain();
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_lookups.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
